// ----- hdl/rna_pkg.sv -----
// Rational ALU package: request/response types, opcodes and status codes.
package rna_pkg;

  localparam int MAG_W = 64;

  localparam logic [3:0] OP_NORM = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_MUL  = 4'd3;
  localparam logic [3:0] OP_DIV  = 4'd4;
  localparam logic [3:0] OP_NEG  = 4'd5;
  localparam logic [3:0] OP_EQ   = 4'd6;
  localparam logic [3:0] OP_LT   = 4'd7;
  localparam logic [3:0] OP_GT   = 4'd8;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [3:0]   req_type;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0]  res_den;
    logic         cmp_true;
    logic [1:0]   status;
  } rsp_t;

endpackage

// ----- hdl/rational_number_alu_unit.sv -----
// Rational-number ALU: gcd-reduced fraction arithmetic and compares.
//
//  channel | signals                       | direction
//  req     | req_valid, req_ready, req     | in
//  rsp     | rsp_valid, rsp_ready, rsp     | out
//
// One request at a time. Each used operand is reduced by a binary gcd
// and two restoring divides of PART_WIDTH bits; arithmetic results take
// three products on the shared multiplier, then a 64-bit gcd and two
// 64-bit divides. A request that is rejected up front skips the gcd and
// divider loops and goes straight to the response.
// Reset (rst, synchronous) returns to idle and drops rsp_valid.
// A response waiting on rsp_ready does not block the next request.
module rational_number_alu_unit #(
  parameter int PART_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  input  rna_pkg::req_t req,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output rna_pkg::rsp_t rsp
);
  import rna_pkg::*;

  localparam int PW = PART_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_COMB = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_R = 2'd2;

  logic [2:0] state;
  logic [1:0] phase;
  logic [3:0] op;

  // raw operand b, held until a is reduced
  logic          bx_neg, by_neg;
  logic [PW-1:0] bx_m, by_m;

  // reduced operands: sign on the numerator
  logic          a_s, b_s;
  logic [PW-1:0] an_m, ad_m, bn_m, bd_m;

  // value under reduction
  logic             rs;
  logic [MAG_W-1:0] rn_m, rd_m;

  // gcd unit
  logic [MAG_W-1:0] u, v;
  logic [5:0]       k;

  // divider
  logic [MAG_W-1:0] dvd, dvs, rem;
  logic [6:0]       cnt;
  logic             which;

  // multiplier
  logic [1:0]       msel;
  logic [PW-1:0]    mx, my;
  logic [MAG_W-1:0] p0, p1, p2;

  // result staging
  logic signed [63:0] r_num;
  logic [62:0]        r_den;
  logic               r_cmp;
  logic [1:0]         r_st;

  // input decode
  logic          ax_neg, ay_neg, bxn_i, byn_i, binary;
  logic [PW-1:0] ax_m, ay_m, bxm_i, bym_i;

  assign ax_neg = req.a_num[PW-1];
  assign ay_neg = req.a_den[PW-1];
  assign bxn_i  = req.b_num[PW-1];
  assign byn_i  = req.b_den[PW-1];
  assign ax_m   = ax_neg ? (~req.a_num[PW-1:0] + 1'b1) : req.a_num[PW-1:0];
  assign ay_m   = ay_neg ? (~req.a_den[PW-1:0] + 1'b1) : req.a_den[PW-1:0];
  assign bxm_i  = bxn_i ? (~req.b_num[PW-1:0] + 1'b1) : req.b_num[PW-1:0];
  assign bym_i  = byn_i ? (~req.b_den[PW-1:0] + 1'b1) : req.b_den[PW-1:0];
  assign binary = (req.req_type == OP_ADD) || (req.req_type == OP_SUB) ||
                  (req.req_type == OP_MUL) || (req.req_type == OP_DIV) ||
                  (req.req_type == OP_EQ)  || (req.req_type == OP_LT)  ||
                  (req.req_type == OP_GT);

  logic op_bin;
  assign op_bin = (op != OP_NORM) && (op != OP_NEG);

  // divider step
  logic [MAG_W:0]   rem_sh, rem_dif;
  logic             ge;
  logic [MAG_W-1:0] qnext;
  assign rem_sh  = {rem, dvd[MAG_W-1]};
  assign rem_dif = rem_sh - {1'b0, dvs};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign qnext   = {dvd[MAG_W-2:0], ge};

  // divisor from gcd
  logic [MAG_W-1:0] gval;
  assign gval = (u | v) << k;

  // multiplier operand select
  always_comb begin
    case (msel)
      2'd0: begin
        mx = an_m;
        my = (op == OP_MUL) ? bn_m : bd_m;
      end
      2'd1: begin
        mx = ad_m;
        my = (op == OP_MUL) ? bd_m : bn_m;
      end
      default: begin
        mx = ad_m;
        my = bd_m;
      end
    endcase
  end

  // cross-product combine
  logic signed [65:0] t1, t2, ssum;
  logic               s_ovf;
  logic [MAG_W-1:0]   s_mag;
  always_comb begin
    t1 = a_s ? -$signed({2'b00, p0}) : $signed({2'b00, p0});
    t2 = b_s ? -$signed({2'b00, p1}) : $signed({2'b00, p1});
    ssum = (op == OP_SUB) ? (t1 - t2) : (t1 + t2);
    s_ovf = !((ssum[65:63] == 3'b000) || (ssum[65:63] == 3'b111));
    s_mag = ssum[65] ? MAG_W'(-ssum) : ssum[MAG_W-1:0];
  end

  // final range check
  logic f_ovf;
  assign f_ovf = qnext[MAG_W-1] ||
                 (rs ? (rn_m > {1'b1, {(MAG_W-1){1'b0}}}) : rn_m[MAG_W-1]);

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == S_OUT) && (!rsp_valid || rsp_ready)) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op     <= req.req_type;
            bx_neg <= bxn_i;
            by_neg <= byn_i;
            bx_m   <= bxm_i;
            by_m   <= bym_i;
            r_num  <= '0;
            r_den  <= 63'd1;
            r_cmp  <= 1'b0;
            if (req.req_type > OP_GT) begin
              r_st  <= ST_OK;
              state <= S_OUT;
            end else if ((ay_m == '0) || (binary && (bym_i == '0)) ||
                         ((req.req_type == OP_DIV) && (bxm_i == '0))) begin
              r_st  <= ST_ZDEN;
              state <= S_OUT;
            end else begin
              r_st  <= ST_OK;
              rs    <= ax_neg ^ ay_neg;
              rn_m  <= MAG_W'(ax_m);
              rd_m  <= MAG_W'(ay_m);
              u     <= MAG_W'(ax_m);
              v     <= MAG_W'(ay_m);
              k     <= '0;
              phase <= PH_A;
              state <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if ((u == '0) || (v == '0)) begin
            dvs   <= gval;
            dvd   <= (phase == PH_R) ? rn_m : (rn_m << (MAG_W - PW));
            rem   <= '0;
            cnt   <= (phase == PH_R) ? 7'(MAG_W) : 7'(PW);
            which <= 1'b0;
            state <= S_DIV;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 1'b1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u >= v) begin
            u <= u - v;
          end else begin
            v <= v - u;
          end
        end
        S_DIV: begin
          if (cnt != 7'd1) begin
            rem <= ge ? rem_dif[MAG_W-1:0] : rem_sh[MAG_W-1:0];
            dvd <= qnext;
            cnt <= cnt - 1'b1;
          end else if (!which) begin
            rn_m  <= qnext;
            dvd   <= (phase == PH_R) ? rd_m : (rd_m << (MAG_W - PW));
            rem   <= '0;
            cnt   <= (phase == PH_R) ? 7'(MAG_W) : 7'(PW);
            which <= 1'b1;
          end else begin
            case (phase)
              PH_A: begin
                a_s  <= rs;
                an_m <= rn_m[PW-1:0];
                ad_m <= qnext[PW-1:0];
                if (op_bin) begin
                  rs    <= bx_neg ^ by_neg;
                  rn_m  <= MAG_W'(bx_m);
                  rd_m  <= MAG_W'(by_m);
                  u     <= MAG_W'(bx_m);
                  v     <= MAG_W'(by_m);
                  k     <= '0;
                  phase <= PH_B;
                  state <= S_GCD;
                end else begin
                  r_num <= (rs ^ (op == OP_NEG)) ? -$signed(rn_m) : $signed(rn_m);
                  r_den <= qnext[62:0];
                  state <= S_OUT;
                end
              end
              PH_B: begin
                b_s   <= rs;
                bn_m  <= rn_m[PW-1:0];
                bd_m  <= qnext[PW-1:0];
                msel  <= 2'd0;
                state <= S_MUL;
              end
              default: begin
                if (f_ovf) begin
                  r_st <= ST_OVF;
                end else begin
                  r_num <= rs ? -$signed(rn_m) : $signed(rn_m);
                  r_den <= qnext[62:0];
                end
                state <= S_OUT;
              end
            endcase
          end
        end
        S_MUL: begin
          case (msel)
            2'd0:    p0 <= MAG_W'(mx * my);
            2'd1:    p1 <= MAG_W'(mx * my);
            default: p2 <= MAG_W'(mx * my);
          endcase
          msel <= msel + 1'b1;
          if (msel == 2'd2) state <= S_COMB;
        end
        S_COMB: begin
          case (op)
            OP_EQ: begin
              r_cmp <= (t1 == t2);
              state <= S_OUT;
            end
            OP_LT: begin
              r_cmp <= (t1 < t2);
              state <= S_OUT;
            end
            OP_GT: begin
              r_cmp <= (t1 > t2);
              state <= S_OUT;
            end
            OP_ADD, OP_SUB: begin
              if (s_ovf) begin
                r_st  <= ST_OVF;
                state <= S_OUT;
              end else begin
                rs    <= ssum[65];
                rn_m  <= s_mag;
                rd_m  <= p2;
                u     <= s_mag;
                v     <= p2;
                k     <= '0;
                phase <= PH_R;
                state <= S_GCD;
              end
            end
            default: begin
              rs    <= a_s ^ b_s;
              rn_m  <= p0;
              rd_m  <= p1;
              u     <= p0;
              v     <= p1;
              k     <= '0;
              phase <= PH_R;
              state <= S_GCD;
            end
          endcase
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.res_num  <= r_num;
            rsp.res_den  <= r_den;
            rsp.cmp_true <= r_cmp;
            rsp.status   <= r_st;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> (rsp.res_num == 0) && (rsp.res_den == 63'd1)
                                           && !rsp.cmp_true)
    else $error("error response carries a value");

  a_cmp_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.cmp_true |-> (rsp.res_num == 0) && (rsp.res_den == 63'd1))
    else $error("compare response carries a value");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.res_den != '0))
    else $error("zero denominator in response");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_OUT))
    else $error("response raised outside output state");

endmodule
